>>> rtl/i2c_angle_frame_to_text_line_core_assert.svh
// Assertion helpers for the angle frame to text line block.
`ifndef I2C_ANGLE_FRAME_TO_TEXT_LINE_CORE_ASSERT_SVH
`define I2C_ANGLE_FRAME_TO_TEXT_LINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IAFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IAFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iaft_pkg.sv
package iaft_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam int FRAME_LEN = 4;

  // Line program: literal characters and two number slots
  localparam int NUM_STEPS = 13;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = step_t'(NUM_STEPS - 1);

  typedef struct packed {
    logic       is_num;
    logic       is_y;
    logic [7:0] ch;
  } slot_t;

  function automatic slot_t slot_at(input step_t step);
    slot_t s;
    s = '{is_num: 1'b0, is_y: 1'b0, ch: 8'h20};
    case (step)
      step_t'(0):  s.ch = 8'h58;
      step_t'(1):  s.ch = 8'h3A;
      step_t'(2):  s.ch = 8'h20;
      step_t'(3):  s.is_num = 1'b1;
      step_t'(4):  s.ch = 8'h20;
      step_t'(5):  s.ch = 8'h7C;
      step_t'(6):  s.ch = 8'h20;
      step_t'(7):  s.ch = 8'h59;
      step_t'(8):  s.ch = 8'h3A;
      step_t'(9):  s.ch = 8'h20;
      step_t'(10): begin
        s.is_num = 1'b1;
        s.is_y   = 1'b1;
      end
      step_t'(11): s.ch = CHAR_CR;
      step_t'(12): s.ch = CHAR_LF;
      default:     s.ch = CHAR_LF;
    endcase
    return s;
  endfunction

  // Decimal digit positions, most significant first
  localparam int NUM_DIGITS = 5;
  localparam int POW_W      = $clog2(NUM_DIGITS);
  typedef logic [POW_W-1:0] pow_t;
  localparam pow_t TOP_POW  = pow_t'(NUM_DIGITS - 1);

  function automatic logic [15:0] pow10(input pow_t p);
    logic [15:0] v;
    case (p)
      pow_t'(0): v = 16'd1;
      pow_t'(1): v = 16'd10;
      pow_t'(2): v = 16'd100;
      pow_t'(3): v = 16'd1000;
      pow_t'(4): v = 16'd10000;
      default:   v = 16'd1;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic        load;
    logic        sub;
    logic        shift;
    logic [15:0] value;
  } dig_ctrl_t;

  typedef struct packed {
    logic       ge;
    logic [3:0] digit;
    logic       pow_zero;
  } dig_stat_t;

endpackage

>>> rtl/iaft_intf.sv
interface iaft_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface iaft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       led_on;

  modport source (output valid, text_char, last_char, led_on, input ready);
  modport sink   (input valid, text_char, last_char, led_on, output ready);
endinterface

>>> rtl/iaft_frame_store.sv
module iaft_frame_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic [15:0] x_raw,
  output logic [15:0] y_raw,
  output logic        led
);
  import iaft_pkg::*;

  logic [7:0] frame_r [FRAME_LEN];
  logic [2:0] idx_r;
  logic       led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_LEN; i++) frame_r[i] <= '0;
      idx_r <= '0;
      led_r <= 1'b0;
    end else if (accept) begin
      case (command)
        CMD_START: idx_r <= '0;
        CMD_DATA: begin
          // drop bytes beyond the fourth
          if (idx_r < 3'(FRAME_LEN)) begin
            frame_r[idx_r[1:0]] <= data_byte;
            idx_r <= idx_r + 3'd1;
          end
        end
        CMD_STOP: led_r <= ~led_r;
        default: ;
      endcase
    end
  end

  assign x_raw = {frame_r[0], frame_r[1]};
  assign y_raw = {frame_r[2], frame_r[3]};
  assign led   = led_r;
endmodule

>>> rtl/iaft_digit_unit.sv
module iaft_digit_unit (
  input  logic                clk,
  input  iaft_pkg::dig_ctrl_t ctrl,
  output iaft_pkg::dig_stat_t stat
);
  import iaft_pkg::*;

  logic [15:0] mag_r;
  logic [3:0]  digit_r;
  pow_t        pow_r;
  logic [15:0] p;
  logic        ge;

  assign p  = pow10(pow_r);
  assign ge = (mag_r >= p);

  // Repeated subtraction of the current power of ten
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r   <= ctrl.value;
      digit_r <= '0;
      pow_r   <= TOP_POW;
    end else if (ctrl.sub) begin
      if (ge) begin
        mag_r   <= mag_r - p;
        digit_r <= digit_r + 4'd1;
      end
    end else if (ctrl.shift) begin
      digit_r <= '0;
      pow_r   <= pow_r - pow_t'(1);
    end
  end

  assign stat.ge       = ge;
  assign stat.digit    = digit_r;
  assign stat.pow_zero = (pow_r == '0);
endmodule

>>> rtl/i2c_angle_frame_to_text_line_core.sv
// Channel   Dir  Payload                          Handshake
// in_chan   in   command[1:0], data_byte[7:0]     valid/ready
// out_chan  out  text_char[7:0], last_char, led_on valid/ready
//
// A stop event starts the line.
// A line holds 11 literal characters and two numbers; each number is worked out
// over five decimal positions by the shared compare/subtract unit, which finds
// one decimal digit at a time by repeated subtraction.
// in_chan is not ready while a line is being formed; an output stall holds the
// sequencer on the waiting character. Reset is synchronous, active low, and
// clears the frame bytes, byte index and LED.
`include "i2c_angle_frame_to_text_line_core_assert.svh"

module i2c_angle_frame_to_text_line_core (
  input logic        clk,
  input logic        rst_n,
  iaft_in_if.sink    in_chan,
  iaft_out_if.source out_chan
);
  import iaft_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SLOT, ST_DIV, ST_PUT} state_t;

  state_t      state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        started_r, started_nxt;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;
  logic        out_led_r;

  logic        in_acc;
  logic        out_free;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic        show;
  slot_t       slot;
  logic [15:0] raw;
  logic [15:0] x_raw, y_raw;
  logic        led;
  dig_ctrl_t   dctrl;
  dig_stat_t   dstat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign out_free      = ~out_valid_r | out_chan.ready;

  iaft_frame_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .command   (in_chan.command),
    .data_byte (in_chan.data_byte),
    .x_raw     (x_raw),
    .y_raw     (y_raw),
    .led       (led)
  );

  iaft_digit_unit u_digit (
    .clk  (clk),
    .ctrl (dctrl),
    .stat (dstat)
  );

  assign slot = slot_at(step_r);
  assign raw  = slot.is_y ? y_raw : x_raw;
  assign show = (dstat.digit != 4'd0) | started_r | dstat.pow_zero;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    started_nxt = started_r;
    dctrl       = '0;
    emit        = 1'b0;
    emit_char   = CHAR_ZERO;
    emit_last   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_chan.command == CMD_STOP) begin
          step_nxt  = '0;
          state_nxt = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (slot.is_num) begin
          // sign needs the output register, a non-negative value does not
          if (out_free || !raw[15]) begin
            dctrl.load  = 1'b1;
            dctrl.value = raw[15] ? (~raw + 16'd1) : raw;
            emit        = raw[15];
            emit_char   = CHAR_MINUS;
            started_nxt = 1'b0;
            state_nxt   = ST_DIV;
          end
        end else if (out_free) begin
          emit      = 1'b1;
          emit_char = slot.ch;
          emit_last = (step_r == LAST_STEP);
          if (step_r == LAST_STEP) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + step_t'(1);
          end
        end
      end
      ST_DIV: begin
        if (dstat.ge) begin
          dctrl.sub = 1'b1;
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!show || out_free) begin
          emit        = show;
          emit_char   = CHAR_ZERO + {4'd0, dstat.digit};
          started_nxt = started_r | show;
          if (dstat.pow_zero) begin
            step_nxt  = step_r + step_t'(1);
            state_nxt = ST_SLOT;
          end else begin
            dctrl.shift = 1'b1;
            state_nxt   = ST_DIV;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      started_r <= started_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
      out_led_r  <= led;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.text_char = out_char_r;
  assign out_chan.last_char = out_last_r;
  assign out_chan.led_on    = out_led_r;

  `IAFT_ASSERT_NOW(a_no_overwrite, emit && out_valid_r, out_chan.ready, "held item overwritten")
  `IAFT_ASSERT_NEXT(a_stop_starts, in_acc && in_chan.command == CMD_STOP, state_r == ST_SLOT && step_r == '0, "stop did not start a line")
  `IAFT_ASSERT_NOW(a_digit_range, state_r == ST_PUT, dstat.digit <= 4'd9, "decimal digit out of range")
  `IAFT_ASSERT_NOW(a_last_is_lf, out_valid_r && out_last_r, out_char_r == CHAR_LF, "last item is not LF")

endmodule

>>> bench/tb_i2c_angle_frame_to_text_line_core.sv
module tb_i2c_angle_frame_to_text_line_core;
  import iaft_pkg::*;

  // Digit work on a number runs with no handshake, and receiver stalls
  // add further idle time, so allow plenty.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       led;
  } line_char_t;

  logic clk;
  logic rst_n;

  iaft_in_if  in_chan();
  iaft_out_if out_chan();

  i2c_angle_frame_to_text_line_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Line predictor state
  logic [7:0]  frame_q [4];
  logic [2:0]  byte_idx;
  logic        led_q;
  line_char_t  pending_chars [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int chars_seen;
  int lines_built;
  int items_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_char(logic [7:0] ch, logic last);
    line_char_t c;
    c.ch   = ch;
    c.last = last;
    c.led  = led_q;
    pending_chars.push_back(c);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endfunction

  function automatic void push_number(logic [15:0] raw);
    int         mag;
    int         count;
    logic [7:0] digits [5];
    count = 0;
    if (raw[15]) begin
      push_char(CHAR_MINUS, 1'b0);
      mag = 65536 - int'(raw);
    end else begin
      mag = int'(raw);
    end
    if (mag == 0) begin
      push_char(CHAR_ZERO, 1'b0);
    end else begin
      while (mag > 0) begin
        digits[count] = CHAR_ZERO + 8'(mag % 10);
        count++;
        mag = mag / 10;
      end
      while (count > 0) begin
        count--;
        push_char(digits[count], 1'b0);
      end
    end
  endfunction

  function automatic void predict_line(cmd_t cmd, logic [7:0] b);
    case (cmd)
      CMD_START: byte_idx = 3'd0;
      CMD_DATA: begin
        // drop bytes beyond the fourth
        if (byte_idx < FRAME_LEN) begin
          frame_q[byte_idx[1:0]] = b;
          byte_idx = byte_idx + 3'd1;
        end
      end
      CMD_STOP: begin
        led_q = ~led_q;
        push_text("X: ");
        push_number({frame_q[0], frame_q[1]});
        push_text(" | Y: ");
        push_number({frame_q[2], frame_q[3]});
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b1);
        lines_built++;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.command   <= cmd;
    in_chan.data_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    predict_line(cmd, b);
    items_sent++;
  endtask

  // Receiver: check each accepted character, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected character: char=%02h last=%0b led=%0b",
                     out_chan.text_char, out_chan.last_char, out_chan.led_on);
        end else begin
          line_char_t want;
          want = pending_chars.pop_front();
          if (out_chan.text_char !== want.ch || out_chan.last_char !== want.last ||
              out_chan.led_on !== want.led) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("character mismatch: expected char=%02h last=%0b led=%0b, got char=%02h last=%0b led=%0b",
                       want.ch, want.last, want.led,
                       out_chan.text_char, out_chan.last_char, out_chan.led_on);
          end
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("no handshake for %0d cycles, %0d characters outstanding",
                   idle_cycles, pending_chars.size());
          $display("tb_i2c_angle_frame_to_text_line_core: errors");
          $finish;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // stop straight after reset prints the zero frame
    send_item(CMD_STOP, 8'h00);
    // largest and most negative values
    send_item(CMD_START, 8'h00);
    send_item(CMD_DATA, 8'h7F);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_STOP, 8'hFF);
    // minus one and one, then extra bytes that must be dropped
    send_item(CMD_START, 8'hFF);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'h01);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_DATA, 8'h55);
    send_item(CMD_STOP, 8'h00);
    // short frame keeps the older Y bytes
    send_item(CMD_START, 8'h00);
    send_item(CMD_DATA, 8'h12);
    send_item(CMD_DATA, 8'h34);
    send_item(CMD_STOP, 8'h00);
    // other event, then stop with no new data
    send_item(CMD_OTHER, 8'hC3);
    send_item(CMD_STOP, 8'h00);
    // data without a start fills the next free slot
    send_item(CMD_DATA, 8'h5A);
    send_item(CMD_STOP, 8'h00);
    send_item(CMD_START, 8'h00);
    send_item(CMD_STOP, 8'h00);
  endtask

  task automatic rand_traffic(int n);
    int   done;
    int   kind;
    int   k;
    cmd_t cmd;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_item(CMD_START, pick_byte());
        repeat (4) send_item(CMD_DATA, pick_byte());
        send_item(CMD_STOP, pick_byte());
        done += 6;
      end else if (kind == 7) begin
        k = $urandom_range(0, 3);
        send_item(CMD_START, pick_byte());
        repeat (k) send_item(CMD_DATA, pick_byte());
        send_item(CMD_STOP, pick_byte());
        done += k + 2;
      end else if (kind == 8) begin
        k = $urandom_range(1, 3);
        send_item(CMD_START, pick_byte());
        repeat (4 + k) send_item(CMD_DATA, pick_byte());
        send_item(CMD_STOP, pick_byte());
        done += 6 + k;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          cmd = cmd_t'($urandom_range(0, 3));
          send_item(cmd, 8'($urandom_range(0, 255)));
          done++;
        end
      end
    end
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rand_traffic(60);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 66;
    recv_stall_pct = 0;
    rand_traffic(60);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    rand_traffic(60);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    rand_traffic(60);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_START;
    in_chan.data_byte  = 8'h00;
    for (int i = 0; i < 4; i++) frame_q[i] = 8'h00;
    byte_idx       = 3'd0;
    led_q          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    chars_seen     = 0;
    lines_built    = 0;
    items_sent     = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    in_chan.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_chars.size() != 0) mismatches++;
    $display("Sent %0d events making %0d text lines; %0d characters checked, %0d mismatches.",
             items_sent, lines_built, chars_seen, mismatches);
    $display("Pacing covered free flow, sender gaps, receiver stalls and both together.");
    if (mismatches == 0) begin
      $display("tb_i2c_angle_frame_to_text_line_core: clean");
    end else begin
      $display("tb_i2c_angle_frame_to_text_line_core: errors");
    end
    $finish;
  end

endmodule
